// ===== rtl/i2a_pkg.sv =====
package i2a_pkg;

    localparam int MAX_FIELD_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF     = 2;

    localparam int VALUE_BITS  = 64;
    localparam int NUM_DIGITS  = 20;
    localparam int DIGIT_BITS  = 4 * NUM_DIGITS;
    localparam int IN_DATA_W   = 72;
    localparam int IN_USER_W   = 4;

    // conversion codes as they arrive
    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_HEXL = 3'd2;
    localparam logic [2:0] OP_HEXU = 3'd3;
    localparam logic [2:0] OP_CHAR = 3'd4;

    // work kinds after classification
    localparam logic [2:0] KIND_DEC  = 3'd0;
    localparam logic [2:0] KIND_HEXL = 3'd1;
    localparam logic [2:0] KIND_HEXU = 3'd2;
    localparam logic [2:0] KIND_CHAR = 3'd3;
    localparam logic [2:0] KIND_BAD  = 3'd4;

    typedef struct packed {
        logic [VALUE_BITS-1:0] mag;
        logic [2:0]            kind;
        logic                  narrow;
        logic                  neg;
        logic [5:0]            width;
        logic                  zfill;
        logic                  left;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

// ===== rtl/integer_to_ascii_formatter.sv =====
// Integer to ASCII field formatter.
// Input stream: one item per integer, with value, field width and fill flags
// in tdata and the conversion code plus the 64-bit flag in tuser. Output
// stream: one ASCII character per item, most significant first, tlast on the
// final character, tuser set on the single result of an unsupported code.
// A classifier takes items into a small queue as long as it has room, so
// the input side keeps flowing while the formatter works or the output
// stalls. The formatter takes one queued item at a time: it pops the item,
// runs double-dabble over the value bits for a 32-bit or 64-bit decimal
// value, skips that for hex or character codes, lays out the field, then
// gives one character per cycle while the receiver holds tready high.
// The double-dabble shifter sets the pace of decimal items.
// When the receiver drops tready the output register holds its character
// and the formatter waits; the queue keeps accepting until full.
// Reset empties the queue, returns the formatter to idle and drops tvalid.
module integer_to_ascii_formatter #(
    parameter int MAX_FIELD_WIDTH = i2a_pkg::MAX_FIELD_WIDTH_DEF,
    parameter int QUEUE_DEPTH     = i2a_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // value[63:0], field_width[69:64], zero_fill[70], pad_left[71]
    input  logic [i2a_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // opcode[2:0], wide[3]
    input  logic [i2a_pkg::IN_USER_W-1:0] i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // char_out[7:0]
    output logic [7:0]                    o_m_axis_tdata,
    output logic                          o_m_axis_tlast,
    // bad_type[0]
    output logic                          o_m_axis_tuser
);
    import i2a_pkg::*;

    t_job   front_job;
    t_job   queue_job;
    t_qstat qstat;
    logic   push;
    logic   pop;

    assign o_s_axis_tready = !qstat.full;
    assign push            = i_s_axis_tvalid && !qstat.full;

    i2a_front #(
        .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
    ) u_front (
        .i_tdata (i_s_axis_tdata),
        .i_tuser (i_s_axis_tuser),
        .o_job   (front_job)
    );

    i2a_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_stat  (qstat)
    );

    i2a_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (queue_job),
        .i_qstat         (qstat),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

// ===== rtl/i2a_front.sv =====
module i2a_front #(
    parameter int MAX_FIELD_WIDTH = i2a_pkg::MAX_FIELD_WIDTH_DEF
) (
    input  logic [i2a_pkg::IN_DATA_W-1:0] i_tdata,
    input  logic [i2a_pkg::IN_USER_W-1:0] i_tuser,
    output i2a_pkg::t_job                 o_job
);
    import i2a_pkg::*;

    localparam logic [6:0] MAXW = 7'(MAX_FIELD_WIDTH);

    logic [63:0] value;
    logic [2:0]  opcode;
    logic        wide;
    logic [5:0]  fwidth;
    logic [63:0] v;
    logic [63:0] negv;
    logic        sign;

    assign value  = i_tdata[63:0];
    assign fwidth = i_tdata[69:64];
    assign opcode = i_tuser[2:0];
    assign wide   = i_tuser[3];

    assign v    = wide ? value : {32'b0, value[31:0]};
    assign negv = (~v) + 64'd1;
    assign sign = wide ? v[63] : v[31];

    always_comb begin
        o_job.mag    = v;
        o_job.kind   = KIND_BAD;
        o_job.narrow = !wide;
        o_job.neg    = 1'b0;
        o_job.zfill  = i_tdata[70];
        o_job.left   = i_tdata[71];
        o_job.width  = ({1'b0, fwidth} > MAXW) ? MAXW[5:0] : fwidth;
        case (opcode)
            OP_SDEC: begin
                o_job.kind = KIND_DEC;
                if (sign) begin
                    o_job.neg = 1'b1;
                    o_job.mag = wide ? negv : {32'b0, negv[31:0]};
                end
            end
            OP_UDEC: o_job.kind = KIND_DEC;
            OP_HEXL: o_job.kind = KIND_HEXL;
            OP_HEXU: o_job.kind = KIND_HEXU;
            OP_CHAR: o_job.kind = wide ? KIND_BAD : KIND_CHAR;
            default: o_job.kind = KIND_BAD;
        endcase
    end

endmodule

// ===== rtl/i2a_fifo.sv =====
module i2a_fifo #(
    parameter int DEPTH = i2a_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  i2a_pkg::t_job   i_job,
    input  logic            i_pop,
    output i2a_pkg::t_job   o_job,
    output i2a_pkg::t_qstat o_stat
);
    import i2a_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_job       = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/i2a_back.sv =====
module i2a_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  i2a_pkg::t_job   i_job,
    input  i2a_pkg::t_qstat i_qstat,
    output logic            o_pop,
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,
    output logic            o_m_axis_tlast,
    output logic            o_m_axis_tuser
);
    import i2a_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CONV  = 2'd1;
    localparam logic [1:0] S_SETUP = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;

    logic [1:0]            r_state;
    logic [2:0]            r_kind;
    logic                  r_neg;
    logic [5:0]            r_width;
    logic                  r_zfill;
    logic                  r_left;
    logic [63:0]           r_bin;
    logic [DIGIT_BITS-1:0] r_dw;
    logic [6:0]            r_cnt;
    logic [5:0]            r_k;
    logic [5:0]            r_s;
    logic [5:0]            r_end;
    logic [5:0]            r_sp;
    logic [5:0]            r_lastk;
    logic [7:0]            r_fill;
    logic                  r_ovalid;
    logic [7:0]            r_ochar;
    logic                  r_olast;
    logic                  r_obad;

    logic [DIGIT_BITS-1:0] adj;
    logic [DIGIT_BITS-1:0] n_dw;
    logic [4:0]            dig_cnt;
    logic [5:0]            txt_len;
    logic [5:0]            pad;
    logic [5:0]            n_s;
    logic [5:0]            n_end;
    logic [5:0]            n_sp;
    logic [5:0]            n_lastk;
    logic [4:0]            idx;
    logic [3:0]            nib;
    logic                  in_dig;
    logic [7:0]            n_char;
    logic                  load;

    assign o_pop           = (r_state == S_IDLE) && !i_qstat.empty;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_ochar;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_obad;
    assign load            = (r_state == S_EMIT) && (!r_ovalid || i_m_axis_tready);

    // double-dabble step
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[4*i +: 4] = (r_dw[4*i +: 4] >= 4'd5) ? r_dw[4*i +: 4] + 4'd3
                                                     : r_dw[4*i +: 4];
        end
        n_dw = {adj[DIGIT_BITS-2:0], r_bin[63]};
    end

    // field layout
    always_comb begin
        dig_cnt = 5'd1;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_dw[4*i +: 4] != 4'd0) begin
                dig_cnt = 5'(i + 1);
            end
        end
        if (r_kind == KIND_CHAR) begin
            dig_cnt = 5'd1;
        end
        txt_len = {1'b0, dig_cnt} + {5'd0, r_neg};
        pad     = (r_width > txt_len) ? r_width - txt_len : 6'd0;
        n_s     = {5'd0, r_neg} + (r_left ? pad : 6'd0);
        n_end   = n_s + {1'b0, dig_cnt} - 6'd1;
        n_sp    = (r_left && !r_zfill) ? pad : 6'd0;
        n_lastk = (r_kind == KIND_BAD) ? 6'd0 : txt_len + pad - 6'd1;
    end

    // character at position r_k
    always_comb begin
        idx    = 5'(r_end - r_k);
        nib    = r_dw[{idx, 2'b00} +: 4];
        in_dig = (r_k >= r_s) && (r_k <= r_end);
        if (r_kind == KIND_BAD) begin
            n_char = 8'd0;
        end else if (in_dig) begin
            if (r_kind == KIND_CHAR) begin
                n_char = r_dw[7:0];
            end else if (nib < 4'd10) begin
                n_char = CH_ZERO + {4'd0, nib};
            end else if (r_kind == KIND_HEXU) begin
                n_char = CH_UA + {4'd0, nib} - 8'd10;
            end else begin
                n_char = CH_LA + {4'd0, nib} - 8'd10;
            end
        end else if (r_neg && (r_k == r_sp)) begin
            n_char = CH_MINUS;
        end else begin
            n_char = r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (i_m_axis_tready && !load) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_kind  <= i_job.kind;
                        r_neg   <= i_job.neg;
                        r_width <= i_job.width;
                        r_zfill <= i_job.zfill;
                        r_left  <= i_job.left;
                        r_bin   <= i_job.narrow ? {i_job.mag[31:0], 32'b0} : i_job.mag;
                        r_cnt   <= i_job.narrow ? 7'd32 : 7'd64;
                        if (i_job.kind == KIND_DEC) begin
                            r_dw    <= '0;
                            r_state <= S_CONV;
                        end else if (i_job.kind == KIND_CHAR) begin
                            r_dw    <= {{(DIGIT_BITS-8){1'b0}}, i_job.mag[7:0]};
                            r_state <= S_SETUP;
                        end else begin
                            r_dw    <= {{(DIGIT_BITS-VALUE_BITS){1'b0}}, i_job.mag};
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_CONV: begin
                    r_dw  <= n_dw;
                    r_bin <= {r_bin[62:0], 1'b0};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_s     <= n_s;
                    r_end   <= n_end;
                    r_sp    <= n_sp;
                    r_lastk <= n_lastk;
                    r_fill  <= (r_left && r_zfill) ? CH_ZERO : CH_SPACE;
                    r_k     <= 6'd0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (load) begin
                        r_ovalid <= 1'b1;
                        r_ochar  <= n_char;
                        r_olast  <= (r_k == r_lastk);
                        r_obad   <= (r_kind == KIND_BAD);
                        r_k      <= r_k + 6'd1;
                        if (r_k == r_lastk) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/i2a_checker.sv =====
module i2a_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic [i2a_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    input logic [i2a_pkg::IN_USER_W-1:0] i_s_axis_tuser,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [7:0]                    o_m_axis_tdata,
    input logic                          o_m_axis_tlast,
    input logic                          o_m_axis_tuser
);

    logic out_take;

    assign out_take = o_m_axis_tvalid && i_m_axis_tready;

    // nothing pending out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
            $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser))
        else $error("stalled output changed");

    // waiting input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && !o_s_axis_tready |=>
            i_s_axis_tvalid && $stable(i_s_axis_tdata) && $stable(i_s_axis_tuser))
        else $error("waiting input item changed");

    // error result is a lone zero item
    a_bad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast && (o_m_axis_tdata == 8'd0))
        else $error("bad code result malformed");

    // a field in progress is never cut by an error result
    a_no_bad_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && !o_m_axis_tlast |=> !(o_m_axis_tvalid && o_m_axis_tuser))
        else $error("error result inside a field");

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== test/i2a_stream_checker.sv =====
module i2a_stream_checker #(
    parameter int MAX_FIELD_WIDTH = i2a_pkg::MAX_FIELD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    input  logic                          i_s_axis_tready,
    // value[63:0], field_width[69:64], zero_fill[70], pad_left[71]
    input  logic [i2a_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // opcode[2:0], wide[3]
    input  logic [i2a_pkg::IN_USER_W-1:0] i_s_axis_tuser,
    input  logic                          i_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // char_out[7:0]
    input  logic [7:0]                    i_m_axis_tdata,
    input  logic                          i_m_axis_tlast,
    // bad_type[0]
    input  logic                          i_m_axis_tuser,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_chars_checked,
    output int                            o_bad_seen
);
    import i2a_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       bad;
    } t_field_char;

    t_field_char expected_chars[$];

    function automatic void format_field(input logic [63:0] value, input logic [2:0] opcode,
                                         input logic wide, input logic [5:0] width_in,
                                         input logic zfill, input logic left);
        logic [63:0] v;
        logic [63:0] mag;
        logic [7:0]  digits[0:23];
        logic [7:0]  text[$];
        logic [3:0]  nib;
        logic        neg;
        logic        bad;
        int          n;
        int          width;
        int          pad;
        t_field_char fc;
        v = wide ? value : {32'b0, value[31:0]};
        width = (int'(width_in) > MAX_FIELD_WIDTH) ? MAX_FIELD_WIDTH : int'(width_in);
        mag = v;
        n = 0;
        neg = 1'b0;
        bad = 1'b0;
        case (opcode)
            OP_SDEC, OP_UDEC: begin
                if (opcode == OP_SDEC && (wide ? v[63] : v[31])) begin
                    neg = 1'b1;
                    mag = (~v) + 64'd1;
                    if (!wide) mag[63:32] = '0;
                end
                do begin
                    digits[n] = 8'h30 + 8'(mag % 64'd10);
                    mag = mag / 64'd10;
                    n++;
                end while (mag != 0);
            end
            OP_HEXL, OP_HEXU: begin
                do begin
                    nib = mag[3:0];
                    if (nib < 4'd10) digits[n] = 8'h30 + 8'(nib);
                    else if (opcode == OP_HEXL) digits[n] = 8'h61 + 8'(nib) - 8'd10;
                    else digits[n] = 8'h41 + 8'(nib) - 8'd10;
                    mag = mag >> 4;
                    n++;
                end while (mag != 0);
            end
            OP_CHAR: begin
                if (wide) begin
                    bad = 1'b1;
                end else begin
                    digits[0] = v[7:0];
                    n = 1;
                end
            end
            default: bad = 1'b1;
        endcase
        if (bad) begin
            fc.ch = 8'h00;
            fc.last = 1'b1;
            fc.bad = 1'b1;
            expected_chars.push_back(fc);
            return;
        end
        pad = width - (n + int'(neg));
        if (pad < 0) pad = 0;
        if (left) begin
            if (zfill) begin
                if (neg) text.push_back("-");
                repeat (pad) text.push_back("0");
            end else begin
                repeat (pad) text.push_back(" ");
                if (neg) text.push_back("-");
            end
        end else if (neg) begin
            text.push_back("-");
        end
        for (int i = n - 1; i >= 0; i--) text.push_back(digits[i]);
        if (!left) repeat (pad) text.push_back(" ");
        foreach (text[i]) begin
            fc.ch = text[i];
            fc.last = (i == text.size() - 1);
            fc.bad = 1'b0;
            expected_chars.push_back(fc);
        end
    endfunction

    assign o_pending = expected_chars.size();

    always @(posedge i_clk) begin
        t_field_char fc;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                format_field(i_s_axis_tdata[63:0], i_s_axis_tuser[2:0], i_s_axis_tuser[3],
                             i_s_axis_tdata[69:64], i_s_axis_tdata[70], i_s_axis_tdata[71]);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                o_chars_checked++;
                if (i_m_axis_tuser) o_bad_seen++;
                if (expected_chars.size() == 0) begin
                    $error("unexpected item: char_out %h last %b bad_type %b",
                           i_m_axis_tdata, i_m_axis_tlast, i_m_axis_tuser);
                    o_fail_count++;
                end else begin
                    fc = expected_chars.pop_front();
                    if (i_m_axis_tdata !== fc.ch) begin
                        $error("char_out mismatch: expected %h, got %h", fc.ch, i_m_axis_tdata);
                        o_fail_count++;
                    end
                    if (i_m_axis_tlast !== fc.last) begin
                        $error("last mismatch: expected %b, got %b", fc.last, i_m_axis_tlast);
                        o_fail_count++;
                    end
                    if (i_m_axis_tuser !== fc.bad) begin
                        $error("bad_type mismatch: expected %b, got %b", fc.bad, i_m_axis_tuser);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== test/tb_integer_to_ascii_formatter.sv =====
module tb_integer_to_ascii_formatter;
    import i2a_pkg::*;

    localparam logic [2:0] OP_RSVD_A = 3'd5;
    localparam logic [2:0] OP_RSVD_B = 3'd6;
    localparam logic [2:0] OP_RSVD_C = 3'd7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES = 200;
    localparam int PHASE_ITEMS = 110;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    // value[63:0], field_width[69:64], zero_fill[70], pad_left[71]
    logic [IN_DATA_W-1:0] i_s_axis_tdata;
    // opcode[2:0], wide[3]
    logic [IN_USER_W-1:0] i_s_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    // char_out[7:0]
    logic [7:0]           o_m_axis_tdata;
    logic                 o_m_axis_tlast;
    // bad_type[0]
    logic                 o_m_axis_tuser;

    int fail_count;
    int pending;
    int chars_checked;
    int bad_seen;
    int items_sent;
    int idle_pct;
    int stall_pct;
    int stuck_cycles;

    integer_to_ascii_formatter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    i2a_stream_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_chars_checked (chars_checked),
        .o_bad_seen      (bad_seen)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == WATCHDOG_LIMIT) begin
                $display("tb_integer_to_ascii_formatter failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [63:0] value, input logic [2:0] opcode,
                             input logic wide, input logic [5:0] width,
                             input logic zfill, input logic left);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {left, zfill, width, value};
        i_s_axis_tuser <= {wide, opcode};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        case ($urandom_range(5))
            0: v = 64'($urandom_range(999));
            1: v = {$urandom, $urandom};
            2: v = {$urandom, 32'h8000_0000 + 32'($urandom_range(3)) - 32'd2};
            3: v = 64'h8000_0000_0000_0000 + 64'($urandom_range(3)) - 64'd2;
            4: v = '1 - 64'($urandom_range(15));
            default: v = {$urandom, 32'($urandom_range(127))};
        endcase
        return v;
    endfunction

    task automatic run_random(input int count);
        logic [2:0] opcode;
        logic [5:0] width;
        repeat (count) begin
            if ($urandom_range(9) == 0) opcode = 3'($urandom_range(OP_RSVD_C, OP_RSVD_A));
            else opcode = 3'($urandom_range(OP_CHAR, OP_SDEC));
            if ($urandom_range(7) == 0) width = 6'($urandom_range(63, 25));
            else width = 6'($urandom_range(24));
            send_item(pick_value(), opcode, 1'($urandom), width, 1'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        send_item(64'd0, OP_SDEC, 1'b0, 6'd0, 1'b0, 1'b0);
        send_item(64'hFFFF_FFFF_8000_0000, OP_SDEC, 1'b0, 6'd15, 1'b1, 1'b1);
        send_item(64'h8000_0000_0000_0000, OP_SDEC, 1'b1, 6'd0, 1'b0, 1'b1);
        send_item('1, OP_SDEC, 1'b1, 6'd5, 1'b0, 1'b1);
        send_item(64'h1234_5678_7FFF_FFFF, OP_SDEC, 1'b0, 6'd12, 1'b1, 1'b1);
        send_item(-64'sd42, OP_SDEC, 1'b1, 6'd10, 1'b1, 1'b0);
        send_item(-64'sd5, OP_SDEC, 1'b1, 6'd63, 1'b1, 1'b1);
        send_item('1, OP_UDEC, 1'b1, 6'd32, 1'b1, 1'b1);
        send_item('1, OP_UDEC, 1'b0, 6'd33, 1'b0, 1'b0);
        send_item(64'd123456, OP_UDEC, 1'b1, 6'd3, 1'b0, 1'b1);
        send_item(64'hDEAD_BEEF_CAFE_F00D, OP_HEXL, 1'b1, 6'd20, 1'b0, 1'b0);
        send_item(64'hDEAD_BEEF_CAFE_F00D, OP_HEXU, 1'b0, 6'd12, 1'b1, 1'b1);
        send_item(64'd0, OP_HEXU, 1'b1, 6'd40, 1'b0, 1'b1);
        send_item('1, OP_HEXL, 1'b1, 6'd16, 1'b1, 1'b1);
        send_item(64'h41, OP_CHAR, 1'b0, 6'd4, 1'b1, 1'b1);
        send_item(64'hFFFF_FF00, OP_CHAR, 1'b0, 6'd0, 1'b0, 1'b0);
        send_item(64'hFF, OP_CHAR, 1'b0, 6'd3, 1'b0, 1'b0);
        send_item(64'h41, OP_CHAR, 1'b1, 6'd8, 1'b0, 1'b1);
        send_item(64'd7, OP_RSVD_A, 1'b0, 6'd8, 1'b1, 1'b1);
        send_item(64'd7, OP_RSVD_B, 1'b1, 6'd0, 1'b0, 1'b0);
        send_item('1, OP_RSVD_C, 1'b0, 6'd63, 1'b1, 1'b0);

        // random traffic under each pacing mix
        run_random(PHASE_ITEMS);
        idle_pct = 48;
        run_random(PHASE_ITEMS);
        idle_pct = 0;
        stall_pct = 48;
        run_random(PHASE_ITEMS);
        idle_pct = 30;
        stall_pct = 30;
        run_random(PHASE_ITEMS);

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d items (directed corners plus random under four pacing mixes)",
                 items_sent);
        $display("checked %0d output items, %0d of them unsupported-code results",
                 chars_checked, bad_seen);
        if (fail_count == 0) begin
            $display("tb_integer_to_ascii_formatter passed");
        end else begin
            $display("tb_integer_to_ascii_formatter failed");
        end
        $finish;
    end

endmodule

// ===== integer_to_ascii_formatter.f =====
rtl/i2a_pkg.sv
rtl/i2a_front.sv
rtl/i2a_fifo.sv
rtl/i2a_back.sv
rtl/integer_to_ascii_formatter.sv
rtl/i2a_checker.sv
test/i2a_stream_checker.sv
test/tb_integer_to_ascii_formatter.sv
